// File: rtl/sss_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the seven-segment scanner with encoder.
// No dependencies; sss_encoder.sv, the top level and the testbench use it.
package sss_pkg;

  // Width of the internal wrapping encoder count (8 to 64).
  localparam int POSITION_WIDTH = 32;

  localparam int DIGIT_COUNT = 4;
  localparam int SCAN_WIDTH  = $clog2(DIGIT_COUNT);

  localparam logic [15:0] FLASH_PERIOD_RESET = 16'd50;
  localparam logic [3:0]  BCD_BLANK          = 4'hF;

  // Step event codes on the result channel.
  localparam logic [1:0] STEP_NONE     = 2'd0;
  localparam logic [1:0] STEP_FORWARD  = 2'd1;
  localparam logic [1:0] STEP_BACKWARD = 2'd2;

  // Encoder pin codes, {enc_a, enc_b}.
  localparam logic [1:0] PINS_LOW     = 2'b00;
  localparam logic [1:0] PINS_B_ONLY  = 2'b01;
  localparam logic [1:0] PINS_A_ONLY  = 2'b10;
  localparam logic [1:0] PINS_HIGH    = 2'b11;

  // Encoder status handed to the top level for the current transaction.
  typedef struct packed {
    logic [1:0]                step;
    logic [POSITION_WIDTH-1:0] position;
  } enc_status_t;

endpackage

// File: rtl/sss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: scan tick input, result output, config write.
// Depends on sss_pkg only through its users; widths follow the field list.
interface sss_tick_if;
  logic       valid;
  logic       ready;
  logic       load;
  logic [3:0] digit_first;
  logic [3:0] digit_second;
  logic [3:0] digit_third;
  logic [3:0] digit_fourth;
  logic [3:0] flash_mask;
  logic       enc_a;
  logic       enc_b;

  modport source (
    output valid, load, digit_first, digit_second, digit_third, digit_fourth,
           flash_mask, enc_a, enc_b,
    input  ready
  );
  modport sink (
    input  valid, load, digit_first, digit_second, digit_third, digit_fourth,
           flash_mask, enc_a, enc_b,
    output ready
  );
endinterface

interface sss_result_if;
  logic              valid;
  logic              ready;
  logic [3:0]        bcd_out;
  logic [3:0]        digit_select;
  logic [1:0]        step_event;
  logic signed [31:0] position;

  modport source (
    output valid, bcd_out, digit_select, step_event, position,
    input  ready
  );
  modport sink (
    input  valid, bcd_out, digit_select, step_event, position,
    output ready
  );
endinterface

interface sss_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] flash_period;

  modport source (output valid, flash_period, input ready);
  modport sink (input valid, flash_period, output ready);
endinterface

// File: rtl/sss_encoder.sv
`timescale 1ns / 1ps
// Quadrature detent machine and wrapping signed position count.
// Depends on sss_pkg for pin codes, step codes and enc_status_t.
module sss_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [1:0]           pins,
  output sss_pkg::enc_status_t status
);

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_FWD   = 2'd1,
    PHASE_BWD   = 2'd2,
    PHASE_EQUAL = 2'd3
  } phase_t;

  phase_t                            phase;
  phase_t                            phase_next;
  logic [1:0]                        step_next;
  logic [sss_pkg::POSITION_WIDTH-1:0] position_count;
  logic [sss_pkg::POSITION_WIDTH-1:0] position_next;

  always_comb begin
    phase_next = phase;
    step_next  = sss_pkg::STEP_NONE;
    case (phase)
      PHASE_IDLE: begin
        if (pins == sss_pkg::PINS_A_ONLY) begin
          phase_next = PHASE_FWD;
        end else if (pins == sss_pkg::PINS_B_ONLY) begin
          phase_next = PHASE_BWD;
        end
      end
      PHASE_FWD: begin
        if (pins == sss_pkg::PINS_HIGH) begin
          phase_next = PHASE_EQUAL;
          step_next  = sss_pkg::STEP_FORWARD;
        end else if (pins == sss_pkg::PINS_LOW) begin
          phase_next = PHASE_IDLE;
        end
      end
      PHASE_BWD: begin
        if (pins == sss_pkg::PINS_HIGH) begin
          phase_next = PHASE_EQUAL;
          step_next  = sss_pkg::STEP_BACKWARD;
        end else if (pins == sss_pkg::PINS_LOW) begin
          phase_next = PHASE_IDLE;
        end
      end
      default: begin
        if (pins == sss_pkg::PINS_LOW) begin
          phase_next = PHASE_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    case (step_next)
      sss_pkg::STEP_FORWARD:
        position_next = position_count + sss_pkg::POSITION_WIDTH'(1);
      sss_pkg::STEP_BACKWARD:
        position_next = position_count - sss_pkg::POSITION_WIDTH'(1);
      default:
        position_next = position_count;
    endcase
  end

  assign status.step     = step_next;
  assign status.position = position_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_IDLE;
      position_count <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      position_count <= position_next;
    end
  end

endmodule

// File: rtl/seven_segment_scan_with_encoder_top.sv
`timescale 1ns / 1ps
// Four-digit multiplexed display scanner with flash blanking and a quadrature
// encoder decoder. Each accepted tick transaction loads the result register.
// Throughput: one tick transaction per clock while result.ready is high; the
// result register is the only stage and refills in the cycle it is taken.
// Synchronous active-high rst clears all state (flash period back to 50) and
// holds both ready outputs low; result payload is not reset.
module seven_segment_scan_with_encoder_top (
  input  logic         clk,
  input  logic         rst,
  sss_tick_if.sink     tick,
  sss_result_if.source result,
  sss_cfg_if.sink      cfg
);

  // Configuration: one register, writable whenever out of reset.
  logic [15:0] flash_period;

  // Display state.
  logic [15:0]                  flash_count;
  logic [15:0]                  flash_count_next;
  logic [16:0]                  flash_inc;
  logic                         flash_on;
  logic [sss_pkg::SCAN_WIDTH-1:0] scan_index;
  logic [3:0]                   held_digits [sss_pkg::DIGIT_COUNT];
  logic [3:0]                   held_flash;
  logic [3:0]                   scan_digit;
  logic                         scan_flash;
  logic [3:0]                   bcd_next;

  // Encoder.
  sss_pkg::enc_status_t enc_status;
  logic signed [63:0]   position_ext;

  // Handshake.
  logic accept;

  // Hold off every transaction while in reset.
  assign cfg.ready = !rst;

  // Take a new tick whenever the result register is empty or being drained.
  assign tick.ready = !rst && (!result.valid || result.ready);
  assign accept     = tick.valid && tick.ready;

  // Flash counter: wrap to zero once the increment passes the period. The
  // increment is one bit wider so a period of 65535 compares correctly.
  assign flash_inc        = {1'b0, flash_count} + 17'd1;
  assign flash_count_next = (flash_inc > {1'b0, flash_period}) ? 16'd0 : flash_inc[15:0];
  assign flash_on         = flash_count_next < (flash_period >> 1);

  // Scan: a load in this tick takes effect before the scan, so pick the
  // incoming digits and mask directly in that case.
  always_comb begin
    if (tick.load) begin
      case (scan_index)
        2'd0:    scan_digit = tick.digit_first;
        2'd1:    scan_digit = tick.digit_second;
        2'd2:    scan_digit = tick.digit_third;
        default: scan_digit = tick.digit_fourth;
      endcase
      scan_flash = tick.flash_mask[scan_index];
    end else begin
      scan_digit = held_digits[scan_index];
      scan_flash = held_flash[scan_index];
    end
  end

  // Blank a flashing position during the off phase.
  assign bcd_next = (!flash_on && scan_flash) ? sss_pkg::BCD_BLANK : scan_digit;

  sss_encoder u_encoder (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .pins    ({tick.enc_a, tick.enc_b}),
    .status  (enc_status)
  );

  // Sign-extend the internal count, then keep the low 32 bits for the port.
  assign position_ext = 64'(signed'(enc_status.position));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_period <= sss_pkg::FLASH_PERIOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      flash_period <= cfg.flash_period;
    end
  end

  // Per-tick state: advance the flash counter and scan position, hold new
  // digits on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_count <= '0;
      scan_index  <= '0;
      held_flash  <= '0;
      for (int i = 0; i < sss_pkg::DIGIT_COUNT; i++) begin
        held_digits[i] <= '0;
      end
    end else if (accept) begin
      flash_count <= flash_count_next;
      scan_index  <= scan_index + sss_pkg::SCAN_WIDTH'(1);
      if (tick.load) begin
        held_digits[0] <= tick.digit_first;
        held_digits[1] <= tick.digit_second;
        held_digits[2] <= tick.digit_third;
        held_digits[3] <= tick.digit_fourth;
        held_flash     <= tick.flash_mask;
      end
    end
  end

  // Result register: valid is control, the payload loads only on a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.bcd_out      <= bcd_next;
      result.digit_select <= 4'(4'b0001 << scan_index);
      result.step_event   <= enc_status.step;
      result.position     <= position_ext[31:0];
    end
  end

  // Checks.
  a_select_onehot : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot(result.digit_select))
    else $error("digit_select is not one-hot");

  a_scan_rotates : assert property (@(posedge clk) disable iff (rst)
    accept |=> scan_index == $past(scan_index) + sss_pkg::SCAN_WIDTH'(1))
    else $error("scan position did not advance by one");

  a_step_code : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.step_event == sss_pkg::STEP_NONE ||
                      result.step_event == sss_pkg::STEP_FORWARD ||
                      result.step_event == sss_pkg::STEP_BACKWARD))
    else $error("illegal step event code");

  a_select_matches_scan : assert property (@(posedge clk) disable iff (rst)
    accept |=> result.digit_select[$past(scan_index)])
    else $error("result position does not match scan position");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_segment_scan_with_encoder_top: scan ticks,
// flash period writes and a transaction-level predictor of display and encoder.
// Depends on rtl/sss_pkg.sv, rtl/sss_if.sv and the top level module.
module tb_top;

  // Cycle limit with a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 100000;
  localparam int PRINT_CAP   = 40;
  localparam int PHASES      = 8;

  // Encoder detent phases of the predictor.
  typedef enum logic [1:0] {ENC_IDLE, ENC_FWD, ENC_BWD, ENC_EQUAL} enc_phase_t;

  // One scan tick; digits[0] is position one, pins is {enc_a, enc_b}.
  typedef struct packed {
    logic            load;
    logic [3:0][3:0] digits;
    logic [3:0]      mask;
    logic [1:0]      pins;
  } scan_tick_t;

  typedef struct packed {
    logic [3:0]  bcd;
    logic [3:0]  sel;
    logic [1:0]  step;
    logic [31:0] pos;
  } scan_result_t;

  // A directed row may carry a result typed in by hand.
  typedef struct packed {
    logic         known;
    scan_tick_t   t;
    scan_result_t r;
  } directed_row_t;

  typedef struct packed {
    logic         known;
    scan_result_t r;
  } typed_result_t;

  // Forward rotation walks this Gray sequence upward, backward downward.
  localparam logic [1:0] GRAY_WALK [4] = '{sss_pkg::PINS_LOW, sss_pkg::PINS_A_ONLY,
                                           sss_pkg::PINS_HIGH, sss_pkg::PINS_B_ONLY};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sss_tick_if   tick_bus ();
  sss_result_if res_bus ();
  sss_cfg_if    cfg_bus ();

  seven_segment_scan_with_encoder_top u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  // Free-running clock, 2 ns period.
  always #1 clk = ~clk;

  // Predictor state: a private copy of the block's registers.
  logic [15:0]                        period_m;
  logic [15:0]                        flash_count_m;
  logic [1:0]                         scan_m;
  logic [3:0][3:0]                    digits_m;
  logic [3:0]                         flash_mask_m;
  enc_phase_t                         enc_phase_m;
  logic [sss_pkg::POSITION_WIDTH-1:0] enc_count_m;

  scan_result_t  expected_scan_q [$];
  typed_result_t typed_scan_q [$];
  directed_row_t dir_tab [$];

  int mismatch_count = 0;
  int ticks_taken    = 0;
  int results_seen   = 0;
  int period_writes  = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // Advance the predictor by one scan tick and return the display/encoder result.
  function automatic scan_result_t predict_scan_tick(scan_tick_t t);
    logic [16:0]       next_count;
    logic              on_phase;
    logic signed [63:0] wide;
    scan_result_t      r;
    // Flash counter: compare the unwrapped increment against the period.
    next_count    = {1'b0, flash_count_m} + 17'd1;
    flash_count_m = (next_count > {1'b0, period_m}) ? 16'd0 : next_count[15:0];
    on_phase      = (flash_count_m < (period_m >> 1));
    if (t.load) begin
      digits_m     = t.digits;
      flash_mask_m = t.mask;
    end
    r.bcd  = (!on_phase && flash_mask_m[scan_m]) ? sss_pkg::BCD_BLANK : digits_m[scan_m];
    r.sel  = 4'b0001 << scan_m;
    scan_m = scan_m + 2'd1;
    r.step = sss_pkg::STEP_NONE;
    case (enc_phase_m)
      ENC_IDLE: begin
        if (t.pins == sss_pkg::PINS_A_ONLY) enc_phase_m = ENC_FWD;
        else if (t.pins == sss_pkg::PINS_B_ONLY) enc_phase_m = ENC_BWD;
      end
      ENC_FWD: begin
        if (t.pins == sss_pkg::PINS_HIGH) begin
          enc_phase_m = ENC_EQUAL;
          r.step      = sss_pkg::STEP_FORWARD;
        end else if (t.pins == sss_pkg::PINS_LOW) begin
          enc_phase_m = ENC_IDLE;
        end
      end
      ENC_BWD: begin
        if (t.pins == sss_pkg::PINS_HIGH) begin
          enc_phase_m = ENC_EQUAL;
          r.step      = sss_pkg::STEP_BACKWARD;
        end else if (t.pins == sss_pkg::PINS_LOW) begin
          enc_phase_m = ENC_IDLE;
        end
      end
      default: begin
        if (t.pins == sss_pkg::PINS_LOW) enc_phase_m = ENC_IDLE;
      end
    endcase
    if (r.step == sss_pkg::STEP_FORWARD) enc_count_m = enc_count_m + 1'b1;
    else if (r.step == sss_pkg::STEP_BACKWARD) enc_count_m = enc_count_m - 1'b1;
    // Sign-extend the internal count, then keep the low 32 bits.
    wide  = $signed(enc_count_m);
    r.pos = wide[31:0];
    return r;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic directed_row_t mk_row(logic load, logic [15:0] digits, logic [3:0] mask,
                                           logic [1:0] pins, logic known, logic [3:0] bcd,
                                           logic [3:0] sel, logic [1:0] step,
                                           logic [31:0] pos);
    directed_row_t row;
    row.known    = known;
    row.t.load   = load;
    row.t.digits = digits;
    row.t.mask   = mask;
    row.t.pins   = pins;
    row.r.bcd    = bcd;
    row.r.sel    = sel;
    row.r.step   = step;
    row.r.pos    = pos;
    return row;
  endfunction

  // Scoreboard: sample every handshake at the rising edge, before the block updates.
  always @(posedge clk) begin : scoreboard
    scan_tick_t    t;
    scan_result_t  pred;
    scan_result_t  got;
    scan_result_t  want;
    typed_result_t typed;
    if (!rst) begin
      // Track register writes so the predictor uses the same period.
      if (cfg_bus.valid && cfg_bus.ready) period_m = cfg_bus.flash_period;

      // Predict the result of every accepted tick transaction.
      if (tick_bus.valid && tick_bus.ready) begin
        t.load   = tick_bus.load;
        t.digits = {tick_bus.digit_fourth, tick_bus.digit_third,
                    tick_bus.digit_second, tick_bus.digit_first};
        t.mask   = tick_bus.flash_mask;
        t.pins   = {tick_bus.enc_a, tick_bus.enc_b};
        pred     = predict_scan_tick(t);
        // Directed rows with a hand-typed result override the prediction.
        if (typed_scan_q.size() != 0) begin
          typed = typed_scan_q.pop_front();
          if (typed.known) pred = typed.r;
        end
        expected_scan_q.push_back(pred);
        ticks_taken++;
      end

      // Compare every accepted result against the oldest expectation.
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        got.bcd  = res_bus.bcd_out;
        got.sel  = res_bus.digit_select;
        got.step = res_bus.step_event;
        got.pos  = res_bus.position;
        if (expected_scan_q.size() == 0) begin
          report_mismatch("result with no tick pending", got.pos, 32'd0);
        end else begin
          want = expected_scan_q.pop_front();
          if (got.bcd !== want.bcd)
            report_mismatch("bcd_out", 32'(got.bcd), 32'(want.bcd));
          if (got.sel !== want.sel)
            report_mismatch("digit_select", 32'(got.sel), 32'(want.sel));
          if (got.step !== want.step)
            report_mismatch("step_event", 32'(got.step), 32'(want.step));
          if (got.pos !== want.pos)   report_mismatch("position", got.pos, want.pos);
        end
      end
    end
  end

  // Hard stop: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_scan_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side back-pressure: drop ready at random per the current idle rate.
  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one tick transaction: idle at random, then hold valid until accepted.
  task automatic send_tick(scan_tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_bus.valid = 1'b0;
      @(negedge clk);
    end
    tick_bus.load         = t.load;
    tick_bus.digit_first  = t.digits[0];
    tick_bus.digit_second = t.digits[1];
    tick_bus.digit_third  = t.digits[2];
    tick_bus.digit_fourth = t.digits[3];
    tick_bus.flash_mask   = t.mask;
    {tick_bus.enc_a, tick_bus.enc_b} = t.pins;
    tick_bus.valid        = 1'b1;
    do @(posedge clk); while (!tick_bus.ready);
  endtask

  // Drop tick valid and wait until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    tick_bus.valid = 1'b0;
    while (expected_scan_q.size() != 0) @(posedge clk);
    // The trailing waits leave the block fully idle.
    repeat (3) @(posedge clk);
  endtask

  // Write the flash period through the config channel; block must be idle.
  task automatic write_period(logic [15:0] value);
    @(negedge clk);
    cfg_bus.flash_period = value;
    cfg_bus.valid        = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    period_writes++;
  endtask

  initial begin : stimulus
    logic [15:0] plan_period [PHASES];
    int          plan_items  [PHASES];
    scan_tick_t  t;
    int          gray_idx;
    logic        walk_back;
    int          pick;
    typed_result_t typed;

    // Drive every input to a known value from time zero.
    tick_bus.valid        = 1'b0;
    tick_bus.load         = 1'b0;
    tick_bus.digit_first  = 4'h0;
    tick_bus.digit_second = 4'h0;
    tick_bus.digit_third  = 4'h0;
    tick_bus.digit_fourth = 4'h0;
    tick_bus.flash_mask   = 4'h0;
    tick_bus.enc_a        = 1'b0;
    tick_bus.enc_b        = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.flash_period  = 16'd0;

    // Predictor starts from the block's reset state.
    period_m      = sss_pkg::FLASH_PERIOD_RESET;
    flash_count_m = 16'd0;
    scan_m        = 2'd0;
    digits_m      = '0;
    flash_mask_m  = 4'h0;
    enc_phase_m   = ENC_IDLE;
    enc_count_m   = '0;

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sender idle chance 26 percent, receiver 58 percent.
    send_idle_pct = 26;
    recv_idle_pct = 58;

    // Directed table at the reset period of 50: all ticks sit in the on phase.
    // Rows with known = 1 carry a hand-computed result.
    // Each row: load, digits, mask, pins, then known, bcd, sel, step, pos.
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_LOW,
                             1'b1, 4'h0, 4'b0001, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b1, 16'h0F0F, 4'hF, sss_pkg::PINS_LOW,
                             1'b1, 4'h0, 4'b0010, sss_pkg::STEP_NONE, 32'd0));
    // Digits on a tick without load must be ignored.
    dir_tab.push_back(mk_row(1'b0, 16'hFFFF, 4'hF, sss_pkg::PINS_A_ONLY,
                             1'b1, 4'hF, 4'b0100, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_HIGH,
                             1'b1, 4'h0, 4'b1000, sss_pkg::STEP_FORWARD, 32'd1));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_LOW,
                             1'b1, 4'hF, 4'b0001, sss_pkg::STEP_NONE, 32'd1));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_B_ONLY,
                             1'b1, 4'h0, 4'b0010, sss_pkg::STEP_NONE, 32'd1));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_HIGH,
                             1'b1, 4'hF, 4'b0100, sss_pkg::STEP_BACKWARD, 32'd0));
    // Equal phase holds on a repeated high code.
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_HIGH,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_LOW,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_B_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    // Backward detent from zero goes negative.
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_HIGH,
                             1'b1, 4'hF, 4'b0100, sss_pkg::STEP_BACKWARD, 32'hFFFF_FFFF));
    // Equal ignores single-pin codes; forward ignores a stray B.
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_A_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_B_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_LOW,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_A_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_A_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_B_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_HIGH,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'h0000, 4'h0, sss_pkg::PINS_LOW,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    // Fresh loads: mixed digits, all ones, all zeros, then an ignored pattern.
    dir_tab.push_back(mk_row(1'b1, 16'h6789, 4'h5, sss_pkg::PINS_LOW,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b1, 16'hFFFF, 4'hF, sss_pkg::PINS_LOW,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b1, 16'h0000, 4'h0, sss_pkg::PINS_B_ONLY,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));
    dir_tab.push_back(mk_row(1'b0, 16'hA5A5, 4'hA, sss_pkg::PINS_HIGH,
                             1'b0, 4'h0, 4'b0000, sss_pkg::STEP_NONE, 32'd0));

    foreach (dir_tab[i]) begin
      typed.known = dir_tab[i].known;
      typed.r     = dir_tab[i].r;
      typed_scan_q.push_back(typed);
      send_tick(dir_tab[i].t);
    end

    // Random phases: period 0 and 1 keep flashing digits blank, 2 and a small
    // random value flip phase fast, 65535 is the top, 200 then 7 forces the
    // counter above the new period, and the reset value closes the run.
    plan_period[0] = 16'd0;     plan_items[0] = 150;
    plan_period[1] = 16'd1;     plan_items[1] = 150;
    plan_period[2] = 16'd2;     plan_items[2] = 200;
    plan_period[3] = 16'($urandom_range(60, 3));
    plan_items[3]  = 200;
    plan_period[4] = 16'hFFFF;  plan_items[4] = 150;
    plan_period[5] = 16'd200;   plan_items[5] = 200;
    plan_period[6] = 16'd7;     plan_items[6] = 150;
    plan_period[7] = sss_pkg::FLASH_PERIOD_RESET;
    plan_items[7]  = 150;

    gray_idx  = 0;
    walk_back = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      // Swap the idle rates after two phases, then stop idling altogether.
      if (p == 2) begin
        send_idle_pct = 58;
        recv_idle_pct = 26;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      write_period(plan_period[p]);

      for (int n = 0; n < plan_items[p]; n++) begin
        // Mostly clean quadrature rotation with holds, some random pin noise.
        pick = $urandom_range(99);
        if (pick < 8) begin
          t.pins = 2'($urandom_range(3));
        end else if (pick < 30) begin
          t.pins = GRAY_WALK[gray_idx];
        end else begin
          gray_idx = walk_back ? ((gray_idx + 3) % 4) : ((gray_idx + 1) % 4);
          t.pins   = GRAY_WALK[gray_idx];
        end
        if ($urandom_range(99) < 5) walk_back = ~walk_back;
        t.load   = ($urandom_range(99) < 20);
        t.digits = 16'($urandom);
        t.mask   = 4'($urandom);
        send_tick(t);
      end
    end

    // Let every result come home, then wait on for stragglers.
    drain_results();
    repeat (4) @(posedge clk);

    $display("Run covered %0d scan ticks and %0d checked results across %0d period writes,",
             ticks_taken, results_seen, period_writes);
    $display("from period 0 and 1 up to 65535, under three idle patterns; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sss_encoder.sv
rtl/seven_segment_scan_with_encoder_top.sv
sim/tb_top.sv
